@@ rtl/gha_pkg.sv @@
package gha_pkg;

    // Fixed field widths
    localparam int OP_W         = 2;
    localparam int HANDLE_W     = 32;
    localparam int PAYLOAD_W    = 32;
    localparam int GEN_W        = 16;
    localparam int SLOT_FIELD_W = 16;
    localparam int LIVE_W       = 7;

    // Default table size
    localparam int CAPACITY_DEF = 64;

    // Request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2
    } t_opcode;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;   // init sweep write
        logic accept;     // request word taken, reads issued
        logic pop;        // free-stack data back, read generation of popped slot
        logic exec;       // finish operation, load result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last; // last entry of init sweep
        logic is_alloc;   // incoming request is an allocate
        logic out_free;   // result register can take a word
    } t_sts;

endpackage

@@ rtl/gha_if.sv @@
interface gha_req_if;
    import gha_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       opcode;
    logic [HANDLE_W-1:0]   handle;
    logic [PAYLOAD_W-1:0]  payload;

    modport source (output valid, output opcode, output handle, output payload, input ready);
    modport sink   (input valid, input opcode, input handle, input payload, output ready);
endinterface

interface gha_rsp_if;
    import gha_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [HANDLE_W-1:0]   new_handle;
    logic                  success;
    logic [PAYLOAD_W-1:0]  found_payload;
    logic [LIVE_W-1:0]     live_count;

    modport source (output valid, output new_handle, output success, output found_payload,
                    output live_count, input ready);
    modport sink   (input valid, input new_handle, input success, input found_payload,
                    input live_count, output ready);
endinterface

@@ rtl/generational_handle_allocator_top.sv @@
// Generational handle allocator: a table of CAPACITY slots served one request at a time.
// Allocate pops a slot from a LIFO free stack and returns {generation, slot}; release checks
// the handle, bumps the slot's 16-bit generation and pushes it back; lookup checks the handle
// and returns the stored word. Every result word carries the live count. A release or lookup
// result is loaded in S_EXEC after its request is accepted in S_IDLE, and the controller then
// returns to S_IDLE for the next request; allocate first reads the free stack to learn the
// slot and then, in S_POP, reads that slot's generation before S_EXEC. The result register
// lets the next request be accepted while a result waits; a request finishes only once the
// previous result has been taken, so a result that waits holds the next request in S_EXEC.
// After reset an init sweep writes every slot, one per cycle, so no request is accepted
// until the sweep has written the last slot.
module generational_handle_allocator_top #(
    parameter int CAPACITY = gha_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gha_req_if.sink   i_req,
    gha_rsp_if.source o_rsp
);
    import gha_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_req.ready = in_ready;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gha_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_opcode  (i_req.opcode),
        .i_handle  (i_req.handle),
        .i_payload (i_req.payload),
        .o_rsp     (o_rsp)
    );

endmodule

@@ rtl/gha_ctrl.sv @@
module gha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gha_pkg::t_sts i_sts,
    output gha_pkg::t_cmd o_cmd
);
    import gha_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_sts.is_alloc ? S_POP : S_EXEC;
            end
            S_POP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/gha_dp.sv @@
module gha_dp #(
    parameter int CAPACITY = gha_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gha_pkg::t_cmd                  i_cmd,
    output gha_pkg::t_sts                  o_sts,
    input  logic [gha_pkg::OP_W-1:0]       i_opcode,
    input  logic [gha_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [gha_pkg::PAYLOAD_W-1:0]  i_payload,
    gha_rsp_if.source                      o_rsp
);
    import gha_pkg::*;

    localparam int SW = $clog2(CAPACITY);       // slot index bits
    localparam int CW = $clog2(CAPACITY + 1);   // count bits
    localparam int MW = GEN_W + 1;              // generation word: {gen, live}
    localparam logic [SLOT_FIELD_W:0] CAP_LIM   = (SLOT_FIELD_W + 1)'(CAPACITY);
    localparam logic [CW-1:0]         CAP_CNT   = CW'(CAPACITY);
    localparam logic [SW-1:0]         LAST_SLOT = SW'(CAPACITY - 1);
    localparam logic [GEN_W-1:0]      GEN_INIT  = GEN_W'(1);

    // Per-slot memories
    logic [MW-1:0]        r_gen_mem [CAPACITY];
    logic [PAYLOAD_W-1:0] r_pay_mem [CAPACITY];
    logic [SW-1:0]        r_stk_mem [CAPACITY];

    logic [MW-1:0]        r_gen_rd;
    logic [PAYLOAD_W-1:0] r_pay_rd;
    logic [SW-1:0]        r_stk_rd;

    // Request and bookkeeping registers
    logic [OP_W-1:0]      r_op;
    logic [HANDLE_W-1:0]  r_handle;
    logic [PAYLOAD_W-1:0] r_pay;
    logic [SW-1:0]        r_slot;
    logic [CW-1:0]        r_depth;
    logic [CW-1:0]        r_live;
    logic [SW-1:0]        r_clr_addr;

    // Result register
    logic                 r_o_valid;
    logic [HANDLE_W-1:0]  r_o_new_handle;
    logic                 r_o_success;
    logic [PAYLOAD_W-1:0] r_o_found;
    logic [LIVE_W-1:0]    r_o_live;

    logic [CW-1:0]        n_depth;
    logic [CW-1:0]        n_live;

    // Handle check and operation decode
    logic [GEN_W-1:0]        rd_gen;
    logic                    rd_live;
    logic [SLOT_FIELD_W-1:0] h_slot;
    logic [GEN_W-1:0]        h_gen;
    logic                    h_valid;
    logic                    do_alloc;
    logic                    do_release;
    logic                    do_lookup;

    assign rd_gen  = r_gen_rd[MW-1:1];
    assign rd_live = r_gen_rd[0];
    assign h_slot  = r_handle[SLOT_FIELD_W-1:0];
    assign h_gen   = r_handle[HANDLE_W-1:SLOT_FIELD_W];
    assign h_valid = (r_handle != '0) && ({1'b0, h_slot} < CAP_LIM)
                     && (h_gen == rd_gen) && rd_live;

    always_comb begin
        do_alloc   = 1'b0;
        do_release = 1'b0;
        do_lookup  = 1'b0;
        case (r_op)
            OP_ALLOC:   do_alloc   = (r_depth != '0);
            OP_RELEASE: do_release = h_valid;
            OP_LOOKUP:  do_lookup  = h_valid;
            default: begin
                do_alloc = 1'b0;
            end
        endcase
    end

    // Counter updates
    always_comb begin
        n_depth = r_depth;
        n_live  = r_live;
        if (do_alloc) begin
            n_depth = r_depth - CW'(1);
            n_live  = r_live + CW'(1);
        end else if (do_release) begin
            if (r_depth < CAP_CNT) n_depth = r_depth + CW'(1);
            if (r_live != '0)      n_live  = r_live - CW'(1);
        end
    end

    // Memory write selection
    logic             gen_we;
    logic [SW-1:0]    gen_wa;
    logic [MW-1:0]    gen_wd;
    logic             stk_we;
    logic [SW-1:0]    stk_wa;
    logic [SW-1:0]    stk_wd;
    logic             pay_we;

    always_comb begin
        gen_we = 1'b0;
        gen_wa = r_slot;
        gen_wd = {rd_gen, 1'b1};
        stk_we = 1'b0;
        stk_wa = r_depth[SW-1:0];
        stk_wd = r_slot;
        pay_we = 1'b0;
        if (i_cmd.clear_wr) begin
            gen_we = 1'b1;
            gen_wa = r_clr_addr;
            gen_wd = {GEN_INIT, 1'b0};
            stk_we = 1'b1;
            stk_wa = r_clr_addr;
            stk_wd = r_clr_addr;
        end else if (i_cmd.exec && do_alloc) begin
            gen_we = 1'b1;
            pay_we = 1'b1;
        end else if (i_cmd.exec && do_release) begin
            gen_we = 1'b1;
            gen_wd = {rd_gen + GEN_W'(1), 1'b0};
            stk_we = (r_depth < CAP_CNT);
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (gen_we) r_gen_mem[gen_wa] <= gen_wd;
        if (i_cmd.accept) begin
            r_gen_rd <= r_gen_mem[i_handle[SW-1:0]];
        end else if (i_cmd.pop) begin
            r_gen_rd <= r_gen_mem[r_stk_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) r_pay_mem[r_slot] <= r_pay;
        if (i_cmd.accept) r_pay_rd <= r_pay_mem[i_handle[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk_mem[stk_wa] <= stk_wd;
        if (i_cmd.accept) r_stk_rd <= r_stk_mem[SW'(r_depth - CW'(1))];
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_opcode;
            r_handle <= i_handle;
            r_pay    <= i_payload;
            r_slot   <= i_handle[SW-1:0];
        end else if (i_cmd.pop) begin
            r_slot   <= r_stk_rd;
        end
    end

    // Counters and init sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= CAP_CNT;
            r_live     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.exec)     r_depth    <= n_depth;
            if (i_cmd.exec)     r_live     <= n_live;
            if (i_cmd.clear_wr) r_clr_addr <= r_clr_addr + SW'(1);
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_new_handle <= do_alloc ? {rd_gen, SLOT_FIELD_W'(r_slot)} : '0;
            r_o_success    <= do_alloc || do_release || do_lookup;
            r_o_found      <= do_lookup ? r_pay_rd : '0;
            r_o_live       <= LIVE_W'(n_live);
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.new_handle    = r_o_new_handle;
    assign o_rsp.success       = r_o_success;
    assign o_rsp.found_payload = r_o_found;
    assign o_rsp.live_count    = r_o_live;

    // Status to controller
    assign o_sts.clear_last = (r_clr_addr == LAST_SLOT);
    assign o_sts.is_alloc   = (i_opcode == OP_ALLOC);
    assign o_sts.out_free   = !r_o_valid || o_rsp.ready;

endmodule

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    localparam int SLOTS = CAPACITY_DEF;
    // opcode 3 is unassigned: the block must answer with everything zero but the count
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0]  new_handle;
        logic                 success;
        logic [PAYLOAD_W-1:0] found_payload;
        logic [LIVE_W-1:0]    live_count;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gha_req_if req ();
    gha_rsp_if rsp ();

    generational_handle_allocator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the handle table
    logic [PAYLOAD_W-1:0] word_mem [SLOTS];
    bit                   in_use   [SLOTS];
    logic [GEN_W-1:0]     gen_mem  [SLOTS];
    int                   spare_slots [SLOTS];
    int                   spare_top;
    int                   in_use_total;

    t_reply               expected_replies [$];
    logic [HANDLE_W-1:0]  held [$];     // handles known to be live
    logic [HANDLE_W-1:0]  retired [$];  // handles whose slot was released since

    bit calm;  // no idling on either side while set
    int errors;
    int replies_seen;
    int n_alloc_ok, n_full, n_hit, n_miss, n_spare;

    function automatic void table_reset();
        for (int i = 0; i < SLOTS; i++) begin
            word_mem[i]    = '0;
            in_use[i]      = 1'b0;
            gen_mem[i]     = GEN_W'(1);
            spare_slots[i] = i;
        end
        spare_top    = SLOTS;
        in_use_total = 0;
    endfunction

    // handle names a live entry of the current generation
    function automatic bit handle_live(logic [HANDLE_W-1:0] h, output int slot);
        slot = int'(h[SLOT_FIELD_W-1:0]);
        if (h == '0 || slot >= SLOTS) return 1'b0;
        if (h[HANDLE_W-1:SLOT_FIELD_W] != gen_mem[slot] || !in_use[slot]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_reply table_step(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                          logic [PAYLOAD_W-1:0] p);
        t_reply r = '0;
        int slot;
        case (op)
            OP_ALLOC: begin
                if (spare_top > 0) begin
                    spare_top--;
                    slot           = spare_slots[spare_top];
                    word_mem[slot] = p;
                    in_use[slot]   = 1'b1;
                    in_use_total++;
                    r.new_handle   = {gen_mem[slot], SLOT_FIELD_W'(slot)};
                    r.success      = 1'b1;
                end
            end
            OP_RELEASE: begin
                if (handle_live(h, slot)) begin
                    word_mem[slot] = '0;
                    in_use[slot]   = 1'b0;
                    gen_mem[slot]  = gen_mem[slot] + GEN_W'(1);  // wraps at 16 bits
                    spare_slots[spare_top] = slot;
                    spare_top++;
                    in_use_total--;
                    r.success = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (handle_live(h, slot)) begin
                    r.found_payload = word_mem[slot];
                    r.success       = 1'b1;
                end
            end
            default: ;
        endcase
        r.live_count = LIVE_W'(in_use_total);
        return r;
    endfunction

    function automatic void flag(string msg);
        errors++;
        if (errors <= 10) $display("MISMATCH %s", msg);
    endfunction

    // Send one request word; returns what the table should answer
    task automatic send_word(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                             input logic [PAYLOAD_W-1:0] p, output t_reply r);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 9) gap++;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid   <= 1'b1;
        req.opcode  <= op;
        req.handle  <= h;
        req.payload <= p;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        r = table_step(op, h, p);
        expected_replies.push_back(r);

        // bookkeeping for the stimulus
        if (op == OP_ALLOC) begin
            if (r.success) n_alloc_ok++; else n_full++;
            if (r.success && r.new_handle != '0) held.push_back(r.new_handle);
        end else if (op == OP_SPARE) begin
            n_spare++;
        end else if (r.success) begin
            n_hit++;
        end else begin
            n_miss++;
        end
        if (op == OP_RELEASE && r.success) begin
            foreach (held[i]) begin
                if (held[i] == h) begin
                    held.delete(i);
                    break;
                end
            end
            retired.push_back(h);
            if (retired.size() > 32) void'(retired.pop_front());
        end
        @(negedge i_clk);
    endtask

    // Hold off until every answer is back
    task automatic wait_idle();
        req.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Invalid handles against an empty table; only out-of-range slots are named
    task automatic test_empty_table();
        t_reply r;
        send_word(OP_LOOKUP,  32'hFFFF_FFFF, 32'h0, r);
        send_word(OP_RELEASE, 32'h0001_0040, 32'hFFFF_FFFF, r);
        send_word(OP_SPARE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
        send_word(OP_LOOKUP,  32'h0001_FFFF, 32'h0, r);
    endtask

    // Allocate every slot, then one more against the full table and one unused opcode
    task automatic test_fill_until_full();
        t_reply r;
        logic [PAYLOAD_W-1:0] p;
        for (int i = 0; i < SLOTS; i++) begin
            p = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
            send_word(OP_ALLOC, 32'h0, p, r);
        end
        send_word(OP_ALLOC, 32'h0, 32'hDEAD_BEEF, r);
        send_word(OP_SPARE, 32'h0, 32'h0, r);
        wait_idle();
    endtask

    // Stale, corrupted and zero handles; slot reuse after release
    task automatic test_stale_handles();
        t_reply r;
        logic [HANDLE_W-1:0] h;
        h = held[1];
        send_word(OP_LOOKUP,  h, 32'h0, r);
        send_word(OP_LOOKUP,  32'h0, 32'h0, r);
        send_word(OP_RELEASE, h ^ 32'h0001_0000, 32'h0, r);
        send_word(OP_LOOKUP,  32'hFFFF_0000, 32'h0, r);
        send_word(OP_RELEASE, h, 32'h0, r);
        send_word(OP_RELEASE, h, 32'h0, r);
        send_word(OP_LOOKUP,  h, 32'h0, r);
        send_word(OP_ALLOC,   32'h0, 32'h5A5A_A5A5, r);
        send_word(OP_LOOKUP,  r.new_handle, 32'h0, r);
    endtask

    // Mixed traffic that swings between a full and an empty table
    task automatic test_random_mix(input int n);
        t_reply r;
        logic [HANDLE_W-1:0] h;
        logic [OP_W-1:0] op;
        int pick;
        bit grow;
        grow = 1'b1;
        for (int i = 0; i < n; i++) begin
            calm = (i < 250);
            if (i == n / 2) wait_idle();
            if (in_use_total >= SLOTS) grow = 1'b0;
            if (in_use_total == 0) grow = 1'b1;
            if ($urandom_range(99) < 3) grow = !grow;
            pick = $urandom_range(99);
            op   = OP_ALLOC;
            h    = $urandom;
            if (pick < (grow ? 55 : 20)) begin
                op = OP_ALLOC;
            end else if (pick < 70 && held.size() != 0) begin
                h  = held[$urandom_range(held.size() - 1)];
                op = (pick < 50) ? OP_RELEASE : OP_LOOKUP;
                if (grow && pick < 50) op = OP_LOOKUP;
            end else if (pick < 96) begin
                case ($urandom_range(4))
                    0: h = retired.size() ? retired[$urandom_range(retired.size() - 1)]
                                          : 32'h0;
                    1: h = held.size() ? held[$urandom_range(held.size() - 1)]
                                         ^ {GEN_W'($urandom_range(1, 65535)),
                                            SLOT_FIELD_W'(0)}
                                       : $urandom;
                    2: h = $urandom;
                    3: h = 32'h0;
                    default: h = {GEN_W'($urandom), SLOT_FIELD_W'($urandom_range(SLOTS - 1))};
                endcase
                op = $urandom_range(1) ? OP_RELEASE : OP_LOOKUP;
            end else begin
                op = OP_SPARE;
            end
            send_word(op, h, $urandom, r);
        end
        calm = 1'b0;
    endtask

    // Cycle slot 0 through a run of generations; each release retires the old handle
    task automatic test_slot_reuse();
        t_reply r;
        t_reply a;
        logic [HANDLE_W-1:0] h0;
        while (in_use_total < SLOTS) send_word(OP_ALLOC, 32'h0, $urandom, r);
        h0 = '0;
        foreach (held[i]) if (held[i][SLOT_FIELD_W-1:0] == '0) h0 = held[i];
        send_word(OP_RELEASE, h0, 32'h0, r);
        // slot 0 is now the only free slot, so it comes back every time
        for (int k = 0; k < 16; k++) begin
            send_word(OP_ALLOC,   32'h0, $urandom, a);
            send_word(OP_LOOKUP,  h0, 32'h0, r);
            send_word(OP_RELEASE, a.new_handle, 32'h0, r);
            h0 = a.new_handle;
        end
        send_word(OP_LOOKUP,  h0, 32'h0, r);
        send_word(OP_RELEASE, held[0], 32'h0, r);
        send_word(OP_ALLOC,   32'h0, 32'h1234_5678, r);
        send_word(OP_LOOKUP,  r.new_handle, 32'h0, r);
    endtask

    // Response side: random backpressure
    always @(negedge i_clk) begin
        rsp.ready <= calm || ($urandom_range(99) >= 9);
    end

    // Compare each accepted answer with the oldest prediction
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                flag($sformatf("answer %0d arrived with nothing outstanding", replies_seen));
            end else begin
                want = expected_replies.pop_front();
                if (rsp.new_handle !== want.new_handle)
                    flag($sformatf("answer %0d new_handle: expected %h got %h",
                                   replies_seen, want.new_handle, rsp.new_handle));
                if (rsp.success !== want.success)
                    flag($sformatf("answer %0d success: expected %b got %b",
                                   replies_seen, want.success, rsp.success));
                if (rsp.found_payload !== want.found_payload)
                    flag($sformatf("answer %0d found_payload: expected %h got %h",
                                   replies_seen, want.found_payload, rsp.found_payload));
                if (rsp.live_count !== want.live_count)
                    flag($sformatf("answer %0d live_count: expected %0d got %0d",
                                   replies_seen, want.live_count, rsp.live_count));
            end
        end
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        table_reset();
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        req.valid   = 1'b0;
        req.opcode  = OP_ALLOC;
        req.handle  = '0;
        req.payload = '0;
        rsp.ready   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_fill_until_full();
        test_stale_handles();
        test_random_mix(700);
        test_slot_reuse();

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d answers; %0d allocations, %0d rejected as full",
                 replies_seen, n_alloc_ok, n_full);
        $display("summary: %0d valid and %0d invalid handles, %0d unused opcodes",
                 n_hit, n_miss, n_spare);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
